>>> src/arm_pkg.sv
// Shared types and constants for the address region map.
// No dependencies.
`timescale 1ns / 1ps
package arm_pkg;
  localparam int MaxRegionsDef = 16;
  localparam int PageShiftDef  = 12;
  localparam logic [31:0] WinStartRst = 32'h0400_0000;
  localparam logic [31:0] WinEndRst   = 32'hFFFF_F000;

  localparam logic [1:0] FUNC_PLACE  = 2'd0;
  localparam logic [1:0] FUNC_ALLOC  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_WINDOW  = 3'd1;
  localparam logic [2:0] ST_OVERLAP = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_NOFIT   = 3'd4;

  localparam logic REG_WIN_START = 1'b0;
  localparam logic REG_WIN_END   = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] want_start;
    logic [31:0] want_end;
    logic [31:0] want_size;
    logic [31:0] region_flags_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] got_start;
    logic [31:0] got_end;
  } rsp_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch request, clear candidate index
    logic set_cand;  // form try from candidate k
    logic scan_clr;  // restart overlap scan
    logic scan_adv;  // step overlap scan
    logic next_cand; // advance candidate
    logic commit;    // append region
    logic clear;     // empty table
    logic fill_rsp;  // build result
    logic [2:0] st;  // status to report
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic is_place;
    logic is_clear;
    logic full;
    logic try_bad;    // window or wrap failure
    logic wrap;       // alloc start plus size wrapped
    logic scan_done;
    logic hit;        // overlap at current scan entry
    logic cand_last;  // candidate index equals count
  } sts_t;
endpackage

>>> src/arm_if.sv
// Valid/ready channel carrying one payload type.
// No dependencies.
`timescale 1ns / 1ps
interface arm_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/arm_datapath.sv
// Region table, window registers and the try/overlap datapath.
// Depends on arm_pkg.
`timescale 1ns / 1ps
module arm_datapath #(
  parameter int MAX_REGIONS = arm_pkg::MaxRegionsDef,
  parameter int PAGE_SHIFT  = arm_pkg::PageShiftDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  arm_pkg::req_t  req,
  input  logic           cfg_we,
  input  arm_pkg::cfg_t  cfg,
  input  arm_pkg::cmd_t  cmd,
  output arm_pkg::sts_t  sts,
  output arm_pkg::rsp_t  rsp
);
  import arm_pkg::*;
  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [32:0] PMASK = (33'd1 << PAGE_SHIFT) - 33'd1;

  logic [31:0] ws_r, we_r;
  logic [31:0] ent_s [MAX_REGIONS];
  logic [31:0] ent_e [MAX_REGIONS];
  logic [31:0] ent_f [MAX_REGIONS];
  logic [CW-1:0] cnt_r;
  req_t req_r;
  logic [32:0] sz_r;
  logic [CW-1:0] k_r, i_r;
  logic [32:0] a_r, b_r;
  logic [31:0] rs_r, re_r;
  logic [31:0] rd_s_r, rd_e_r;
  logic [2:0] st_r;
  logic [31:0] cs_r, ce_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= WinStartRst;
      we_r <= WinEndRst;
    end else if (cfg_we) begin
      if (cfg.index == REG_WIN_START) ws_r <= cfg.data;
      else we_r <= cfg.data;
    end
  end

  // candidate start: window start or end of entry k-1
  always_ff @(posedge clk) begin
    rd_e_r <= ent_e[IW'(k_r - CW'(1))];
  end

  logic [32:0] s_try, e_try;
  always_comb begin
    s_try = (req_r.func == FUNC_ALLOC) ?
            ((k_r == '0) ? {1'b0, ws_r} : {1'b0, rd_e_r}) : {1'b0, req_r.want_start};
    e_try = (req_r.func == FUNC_ALLOC) ? s_try + sz_r : {1'b0, req_r.want_end};
  end

  logic [33:0] b_full;
  assign b_full = ({1'b0, e_try} + {1'b0, PMASK}) & ~{1'b0, PMASK};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req;
      sz_r  <= ({1'b0, req.want_size} + PMASK) & ~PMASK;
      k_r   <= '0;
    end
    if (cmd.next_cand) k_r <= k_r + CW'(1);
    if (cmd.set_cand) begin
      a_r <= s_try & ~PMASK;
      b_r <= b_full[33] ? {1'b1, 32'd0} : b_full[32:0];
    end
    if (cmd.scan_clr) i_r <= '0;
    else if (cmd.scan_adv) i_r <= i_r + CW'(1);
    cs_r <= ent_s[IW'(i_r)];
    ce_r <= ent_e[IW'(i_r)];
    // bounds only for a region that is appended; clear and unused op report zero
    if (cmd.fill_rsp) begin
      st_r <= cmd.st;
      rs_r <= cmd.commit ? a_r[31:0] : 32'd0;
      re_r <= cmd.commit ? b_r[31:0] : 32'd0;
    end
    if (cmd.commit) begin
      ent_s[IW'(cnt_r)] <= a_r[31:0];
      ent_e[IW'(cnt_r)] <= b_r[31:0];
      ent_f[IW'(cnt_r)] <= req_r.region_flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.clear) cnt_r <= '0;
    else if (cmd.commit) cnt_r <= cnt_r + CW'(1);
  end

  // scan compare uses registered entry of previous index
  logic [CW-1:0] ip_r;
  logic          cvalid_r;
  always_ff @(posedge clk) begin
    ip_r <= i_r;
    cvalid_r <= (i_r < cnt_r) && !cmd.scan_clr;
    if (cmd.scan_clr) cvalid_r <= 1'b0;
  end

  logic wrap;
  assign wrap = e_try[32] && (req_r.func == FUNC_ALLOC);

  assign sts.is_alloc = req_r.func == FUNC_ALLOC;
  assign sts.is_place = req_r.func == FUNC_PLACE;
  assign sts.is_clear = req_r.func == FUNC_CLEAR;
  assign sts.full     = cnt_r >= CW'(MAX_REGIONS);
  assign sts.wrap     = wrap;
  assign sts.try_bad  = b_r[32] || !({1'b0, ws_r} <= a_r && a_r < {1'b0, we_r})
                        || !({1'b0, ws_r} <= b_r && b_r < {1'b0, we_r});
  assign sts.scan_done = !cvalid_r && (i_r >= cnt_r) && (ip_r >= cnt_r);
  assign sts.hit = cvalid_r &&
                   (({1'b0, cs_r} <= a_r && a_r < {1'b0, ce_r}) ||
                    (a_r <= {1'b0, cs_r} && {1'b0, cs_r} < b_r));
  assign sts.cand_last = k_r == cnt_r;

  assign rsp.status    = st_r;
  assign rsp.got_start = rs_r;
  assign rsp.got_end   = re_r;

  logic unused;
  assign unused = ^ent_f[0];
endmodule

>>> src/arm_ctrl.sv
// Controller sequencing one request: tries, overlap scan, commit, result.
// Depends on arm_pkg.
`timescale 1ns / 1ps
module arm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  arm_pkg::sts_t sts,
  output arm_pkg::cmd_t cmd
);
  import arm_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_CAND = 3'd2,
                         S_CHK = 3'd3, S_SCAN = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6,
                         S_RD = 3'd7;
  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_clear) begin
          cmd.clear = 1'b1; cmd.st = ST_OK; cmd.fill_rsp = 1'b1;
          state_nxt = S_FIN;
        end else if (sts.is_alloc && sts.full) begin
          cmd.st = ST_FULL; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
        end else if (sts.is_alloc || sts.is_place) begin
          state_nxt = S_RD;
        end else begin
          cmd.st = ST_OK; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
        end
      end
      S_RD: state_nxt = S_CAND;  // entry end read latency
      S_CAND: begin
        if (sts.wrap) begin
          if (sts.cand_last) begin
            cmd.st = ST_NOFIT; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
          end else begin
            cmd.next_cand = 1'b1; state_nxt = S_RD;
          end
        end else begin
          cmd.set_cand = 1'b1; cmd.scan_clr = 1'b1; state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.try_bad) begin
          if (sts.is_place) begin
            cmd.st = ST_WINDOW; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
          end else if (sts.cand_last) begin
            cmd.st = ST_NOFIT; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
          end else begin
            cmd.next_cand = 1'b1; state_nxt = S_RD;
          end
        end else begin
          cmd.scan_adv = 1'b1; state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (sts.is_place) begin
            cmd.st = ST_OVERLAP; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
          end else if (sts.cand_last) begin
            cmd.st = ST_NOFIT; cmd.fill_rsp = 1'b1; state_nxt = S_FIN;
          end else begin
            cmd.next_cand = 1'b1; state_nxt = S_RD;
          end
        end else if (sts.scan_done) begin
          if (sts.full) begin
            cmd.st = ST_FULL; cmd.fill_rsp = 1'b1;
          end else begin
            cmd.st = ST_OK; cmd.fill_rsp = 1'b1; cmd.commit = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_commit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> cmd.st == ST_OK) else $error("commit without ok");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_rsp |=> ##1 out_valid) else $error("result lost");
endmodule

>>> src/address_region_map_first_fit.sv
// First-fit address region map: one request in, one result out. The overlap scan reads
// one table entry per cycle, which sets how long a request takes; a result that is not
// taken at once holds off the next accept.
// Window registers: index 0 start, index 1 end. Only one request is in flight.
`timescale 1ns / 1ps
module address_region_map_first_fit #(
  parameter int MAX_REGIONS = arm_pkg::MaxRegionsDef,
  parameter int PAGE_SHIFT  = arm_pkg::PageShiftDef
) (
  input logic clk,
  input logic rst_n,
  arm_if.sink   in_ch,
  arm_if.source out_ch,
  arm_if.sink   cfg_ch
);
  import arm_pkg::*;
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;

  assign cfg_ch.ready = 1'b1;
  assign out_ch.data = rsp;

  arm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd
  );

  arm_datapath #(.MAX_REGIONS(MAX_REGIONS), .PAGE_SHIFT(PAGE_SHIFT)) u_dp (
    .clk, .rst_n, .req(in_ch.data), .cfg_we(cfg_ch.valid), .cfg(cfg_ch.data),
    .cmd, .sts, .rsp
  );
endmodule

>>> verif/tb_address_region_map_first_fit.sv
// Self-checking bench for the first-fit address region map: drives place, allocate
// and clear requests plus window writes, predicts each result in a local table model.
// Depends on arm_pkg, arm_if and address_region_map_first_fit.
`timescale 1ns / 1ps
module tb_address_region_map_first_fit;
  import arm_pkg::*;

  localparam int NREG = MaxRegionsDef;
  localparam logic [63:0] PMASK = (64'd1 << PageShiftDef) - 64'd1;
  localparam longint CYCLE_LIMIT = 64'd4_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  arm_if #(.payload_t(req_t)) in_ch ();
  arm_if #(.payload_t(rsp_t)) out_ch ();
  arm_if #(.payload_t(cfg_t)) cfg_ch ();

  address_region_map_first_fit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [31:0] win_lo, win_hi;
  logic [31:0] tbl_start[NREG];
  logic [31:0] tbl_end[NREG];
  int tbl_count;
  rsp_t expected_rsp[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  int n_ok = 0, n_fail = 0, n_sent = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic [2:0] place_region(input logic [63:0] s, input logic [63:0] e,
                                              output logic [31:0] gs, output logic [31:0] ge);
    logic [63:0] a, b;
    a = s & ~PMASK;
    b = (e + PMASK) & ~PMASK;
    gs = '0; ge = '0;
    if (b > 64'hFFFF_FFFF || !(win_lo <= a && a < win_hi) || !(win_lo <= b && b < win_hi))
      return ST_WINDOW;
    for (int i = 0; i < tbl_count; i++) begin
      if ((tbl_start[i] <= a && a < tbl_end[i]) || (a <= tbl_start[i] && tbl_start[i] < b))
        return ST_OVERLAP;
    end
    if (tbl_count >= NREG) return ST_FULL;
    tbl_start[tbl_count] = a[31:0];
    tbl_end[tbl_count] = b[31:0];
    tbl_count++;
    gs = a[31:0]; ge = b[31:0];
    return ST_OK;
  endfunction

  function automatic rsp_t predict_region_result(input req_t r);
    rsp_t o;
    logic [63:0] sz, s;
    int n;
    o = '0;
    o.status = ST_OK;
    case (r.func)
      FUNC_PLACE: o.status = place_region(r.want_start, r.want_end, o.got_start, o.got_end);
      FUNC_ALLOC: begin
        sz = ({32'd0, r.want_size} + PMASK) & ~PMASK;
        n = tbl_count;
        if (n >= NREG) o.status = ST_FULL;
        else begin
          o.status = ST_NOFIT;
          for (int k = 0; k <= n; k++) begin
            s = (k == 0) ? {32'd0, win_lo} : {32'd0, tbl_end[k-1]};
            if (s + sz > 64'hFFFF_FFFF) continue;
            if (place_region(s, s + sz, o.got_start, o.got_end) == ST_OK) begin
              o.status = ST_OK;
              break;
            end
          end
        end
      end
      FUNC_CLEAR: tbl_count = 0;
      default: ;
    endcase
    if (o.status != ST_OK) begin
      o.got_start = '0; o.got_end = '0;
    end
    if (o.status == ST_OK) n_ok++; else n_fail++;
    return o;
  endfunction

  initial begin
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, change at falling edge
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    rsp_t w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result start", out_ch.data.got_start, 32'd0);
      end else begin
        w = expected_rsp.pop_front();
        if (out_ch.data.status !== w.status)
          report_mismatch("status", 32'(out_ch.data.status), 32'(w.status));
        if (out_ch.data.got_start !== w.got_start)
          report_mismatch("got_start", out_ch.data.got_start, w.got_start);
        if (out_ch.data.got_end !== w.got_end)
          report_mismatch("got_end", out_ch.data.got_end, w.got_end);
      end
    end
  end

  // leaves valid high after accept; the next call drops it or sends anew, drain drops it
  task automatic send_request(input logic [1:0] f, input logic [31:0] ws,
                              input logic [31:0] we, input logic [31:0] sz,
                              input logic [31:0] fl);
    req_t r;
    r.func = f; r.want_start = ws; r.want_end = we; r.want_size = sz;
    r.region_flags_in = fl;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.data <= r;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_rsp.push_back(predict_region_result(r));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_window(input logic idx, input logic [31:0] val);
    cfg_ch.data <= '{index: idx, data: val};
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_WIN_START) win_lo = val; else win_hi = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed;
    send_request(FUNC_ALLOC, '0, '0, 32'd0, 32'hFFFF_FFFF);          // zero size
    send_request(FUNC_PLACE, 32'h0400_0000, 32'h0400_0000, '0, '0);  // empty, no overlap
    send_request(FUNC_PLACE, 32'h1000_0123, 32'h1000_2001, '0, 32'h5); // rounding
    send_request(FUNC_PLACE, 32'h1000_1000, 32'h1000_1800, '0, '0);  // overlap
    send_request(FUNC_PLACE, 32'h2000_5000, 32'h2000_1000, '0, '0);  // inverted
    send_request(FUNC_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);  // end round wraps
    send_request(FUNC_PLACE, 32'h0000_0000, 32'h0000_1000, '0, '0);  // below window
    send_request(FUNC_ALLOC, '0, '0, 32'hFFFF_FFFF, '0);             // wrap
    send_request(FUNC_ALLOC, '0, '0, 32'h0000_2001, 32'hA5A5_5A5A);
    send_request(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 14; i++) send_request(FUNC_ALLOC, '0, '0, 32'h1000, i);
    send_request(FUNC_ALLOC, '0, '0, 32'h1000, '0);                  // full
    send_request(FUNC_PLACE, 32'h9000_0000, 32'h9000_1000, '0, '0);  // full on place
    send_request(FUNC_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(input int count);
    logic [31:0] a, b;
    int c;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99);
      a = win_lo + ($urandom_range(255) << 16) + $urandom_range(32'h1FFF);
      b = a + $urandom_range(32'h6000);
      if (c < 4) send_request(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else if (c < 6) send_request(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom);
      else if (c < 12) send_request(FUNC_PLACE, $urandom, $urandom, $urandom, $urandom);
      else if (c < 45) send_request(FUNC_PLACE, a, b, $urandom, $urandom);
      else if (c < 50) send_request(FUNC_ALLOC, $urandom, $urandom, $urandom, $urandom);
      else send_request(FUNC_ALLOC, $urandom, $urandom, $urandom_range(32'h4000), $urandom);
    end
    drain();
  endtask

  task automatic test_windows;
    write_window(REG_WIN_START, 32'h0000_0000);
    write_window(REG_WIN_END, 32'hFFFF_FFFF);
    test_random(200);
    write_window(REG_WIN_START, 32'hFFFF_FFFF);
    write_window(REG_WIN_END, 32'h0000_0000);
    test_random(40);
    write_window(REG_WIN_START, 32'h8000_0000);
    write_window(REG_WIN_END, 32'h8001_0000);   // tight window, room for 15 pages
    test_random(200);
    write_window(REG_WIN_START, WinStartRst);
    write_window(REG_WIN_END, WinEndRst);
  endtask

  initial begin
    win_lo = WinStartRst; win_hi = WinEndRst; tbl_count = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35; recv_idle_pct = 56;
    test_directed();
    test_random(600);
    send_idle_pct = 56; recv_idle_pct = 35;
    test_windows();
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(700);
    $display("ran %0d requests (%0d ok, %0d refused) over %0d cycles,",
             n_sent, n_ok, n_fail, cycles);
    $display("covering place, allocate, clear, unused op and several windows");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
